// ===== hw/rtl/adl_pkg.sv =====
// Adler-32 checksum unit: shared constants, the lane-to-merge item type and
// the modulo-65521 fold function. No dependencies.
package adl_pkg;

    localparam int DATA_W          = 32;
    localparam int COUNT_W         = 3;
    localparam int HALF_W          = 16;
    localparam int BYTES_PER_ITEM_DEF = 4;
    localparam int BYTES_PER_ITEM_MAX = 16;

    // Lane sums, sized for the largest item (16 bytes)
    localparam int LANE_CNT_W = 5;   // holds 0..16
    localparam int BSUM_W     = 12;  // 16 * 255 = 4080
    localparam int WTERM_W    = 12;  // 255 * 16 = 4080
    localparam int WSUM_W     = 16;  // 255 * 136 = 34680
    localparam int FOLD_W     = 21;  // 65535 * 17 + 34680 < 2**21

    localparam logic [HALF_W:0] ADLER_MOD = 17'd65521;
    // 2**16 mod 65521
    localparam logic [HALF_W:0] FOLD_MUL  = 17'd15;

    // One item after the lane stage
    typedef struct packed {
        logic [BSUM_W-1:0]     byte_sum;
        logic [WSUM_W-1:0]     weight_sum;
        logic [LANE_CNT_W-1:0] cnt;
        logic                  restart;
        logic [DATA_W-1:0]     seed;
    } adl_lane_item_t;

    // Reduce x modulo 65521: fold the bits above 16 with 2**16 = 15 (mod 65521),
    // the folded value stays below twice the modulus.
    function automatic logic [HALF_W-1:0] adl_fold(input logic [FOLD_W-1:0] x);
        logic [HALF_W:0] t;
        t = {1'b0, x[HALF_W-1:0]} + HALF_W'(0) + 17'(x[FOLD_W-1:HALF_W]) * FOLD_MUL;
        if (t >= ADLER_MOD)
        begin
            t = t - ADLER_MOD;
        end
        return t[HALF_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/adl_if.sv =====
// Adler-32 checksum unit: valid/ready channel interfaces for input items
// and checksum results. Depends on adl_pkg.
interface adl_in_if;
    import adl_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [DATA_W-1:0]    data_word;
    logic [COUNT_W-1:0]   byte_count;
    logic                 restart;
    logic [DATA_W-1:0]    seed;

    modport source (output valid, output data_word, output byte_count,
                    output restart, output seed, input ready);
    modport sink   (input valid, input data_word, input byte_count,
                    input restart, input seed, output ready);
endinterface

interface adl_out_if;
    import adl_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [DATA_W-1:0]    checksum;

    modport source (output valid, output checksum, input ready);
    modport sink   (input valid, input checksum, output ready);
endinterface

// ===== hw/rtl/adl_lane.sv =====
// Adler-32 checksum unit: one byte lane. Gives the byte's contribution to
// sum one and its weighted contribution to sum two. Depends on adl_pkg.
module adl_lane #(
    parameter int IDX = 0
) (
    input  logic [7:0]                     lane_byte,
    input  logic [adl_pkg::LANE_CNT_W-1:0] cnt,
    output logic [7:0]                     byte_term,
    output logic [adl_pkg::WTERM_W-1:0]    weight_term
);
    import adl_pkg::*;

    logic                  active;
    logic [LANE_CNT_W-1:0] weight;

    // Drop bytes beyond the count; a byte at position i enters sum two (cnt - i) times
    assign active      = LANE_CNT_W'(IDX) < cnt;
    assign weight      = cnt - LANE_CNT_W'(IDX);
    assign byte_term   = active ? lane_byte : 8'd0;
    assign weight_term = WTERM_W'(13'(byte_term) * 13'(weight));

endmodule

// ===== hw/rtl/adl_merge.sv =====
// Adler-32 checksum unit: merge stage. Holds the running sums, folds in one item's
// lane sums per unstalled cycle, registers the checksum. Depends on adl_pkg, adl_if.
module adl_merge (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s1_valid,
    input  adl_pkg::adl_lane_item_t s1_item,
    output logic                    s1_take,
    adl_out_if.source               result
);
    import adl_pkg::*;

    logic [HALF_W-1:0] sum_one_reg, sum_one_next;
    logic [HALF_W-1:0] sum_two_reg, sum_two_next;
    logic              out_valid_reg;
    logic [DATA_W-1:0] checksum_reg;

    logic [HALF_W-1:0] a0;
    logic [HALF_W-1:0] b0;
    logic [FOLD_W-1:0] a_full;
    logic [FOLD_W-1:0] n_times_a;
    logic [FOLD_W-1:0] b_full;

    // Advance when the result register is empty or being drained
    assign s1_take = s1_valid && (!out_valid_reg || result.ready);

    // Start from the seed on restart, else from the running sums
    assign a0 = s1_item.restart ? s1_item.seed[HALF_W-1:0] : sum_one_reg;
    assign b0 = s1_item.restart ? s1_item.seed[DATA_W-1:HALF_W] : sum_two_reg;

    // sum_two gains cnt copies of the starting sum_one plus the weighted bytes
    assign a_full    = FOLD_W'(a0) + FOLD_W'(s1_item.byte_sum);
    assign n_times_a = FOLD_W'(s1_item.cnt) * FOLD_W'(a0);
    assign b_full    = FOLD_W'(b0) + n_times_a + FOLD_W'(s1_item.weight_sum);

    assign sum_one_next = adl_fold(a_full);
    assign sum_two_next = adl_fold(b_full);

    // Hold state and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_one_reg   <= 16'd1;
            sum_two_reg   <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_take)
            begin
                sum_one_reg   <= sum_one_next;
                sum_two_reg   <= sum_two_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the checksum with the state update
    always_ff @(posedge clk)
    begin
        if (s1_take)
        begin
            checksum_reg <= {sum_two_next, sum_one_next};
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.checksum = checksum_reg;

`ifndef SYNTHESIS
    a_sum_one_range: assert property (@(posedge clk) disable iff (!rst_n)
        17'(sum_one_reg) < ADLER_MOD)
        else $error("sum one out of range");

    a_sum_two_range: assert property (@(posedge clk) disable iff (!rst_n)
        17'(sum_two_reg) < ADLER_MOD)
        else $error("sum two out of range");

    a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> checksum_reg == {sum_two_reg, sum_one_reg})
        else $error("result register disagrees with running sums");

    a_take_fills_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_take |=> out_valid_reg)
        else $error("item taken but no result presented");
`endif

endmodule

// ===== hw/rtl/adler32_checksum_unit.sv =====
// Adler-32 checksum unit: top level. Byte lanes, lane-stage register and
// the merge stage. Depends on adl_pkg, adl_if, adl_lane, adl_merge.
//
// Running Adler-32 over a byte stream, one item per clock cycle sustained
// while the result channel is ready. Each item carries up to BYTES_PER_ITEM
// bytes (first byte in bits 7:0) and returns the checksum after its bytes,
// sum two in bits 31:16 and sum one in bits 15:0. Restart loads the seed (1
// for a fresh checksum) before the item's bytes. Counts above BYTES_PER_ITEM
// saturate; a count of zero adds nothing but still reduces the sums. An
// accepted item passes through the byte lanes, which form the plain and
// weighted byte sums held in the lane-stage register, and then the merge
// stage, whose modulo-65521 update of the running sums registers the checksum
// and sets the one-item-per-cycle rate. A new item is taken while a finished
// result waits, as long as the lane stage has room.
module adler32_checksum_unit #(
    parameter int BYTES_PER_ITEM = adl_pkg::BYTES_PER_ITEM_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    adl_in_if.sink    data_in,
    adl_out_if.source result
);
    import adl_pkg::*;

    localparam int LANES = BYTES_PER_ITEM;

    logic [LANE_CNT_W-1:0] cnt;
    logic [7:0]            byte_terms   [LANES];
    logic [WTERM_W-1:0]    weight_terms [LANES];
    logic [BSUM_W-1:0]     byte_sum;
    logic [WSUM_W-1:0]     weight_sum;

    logic                  s1_valid_reg;
    adl_lane_item_t        s1_item_reg;
    logic                  s1_take;
    logic                  accept;

    // Saturate the count at the lane count
    assign cnt = (LANE_CNT_W'(data_in.byte_count) > LANE_CNT_W'(LANES))
               ? LANE_CNT_W'(LANES) : LANE_CNT_W'(data_in.byte_count);

    // Byte lanes; positions past the data word read as zero
    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        logic [7:0] lane_byte;
        if (i < DATA_W / 8)
        begin : g_data
            assign lane_byte = data_in.data_word[8*i +: 8];
        end
        else
        begin : g_zero
            assign lane_byte = 8'd0;
        end

        adl_lane #(
            .IDX (i)
        ) u_lane (
            .lane_byte   (lane_byte),
            .cnt         (cnt),
            .byte_term   (byte_terms[i]),
            .weight_term (weight_terms[i])
        );
    end

    // Add up the lane terms
    always_comb
    begin
        byte_sum   = '0;
        weight_sum = '0;
        for (int i = 0; i < LANES; i++)
        begin
            byte_sum   = byte_sum + BSUM_W'(byte_terms[i]);
            weight_sum = weight_sum + WSUM_W'(weight_terms[i]);
        end
    end

    // Lane stage takes an item when empty or when the merge stage drains it
    assign data_in.ready = !s1_valid_reg || s1_take;
    assign accept        = data_in.valid && data_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_take)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg.byte_sum   <= byte_sum;
            s1_item_reg.weight_sum <= weight_sum;
            s1_item_reg.cnt        <= cnt;
            s1_item_reg.restart    <= data_in.restart;
            s1_item_reg.seed       <= data_in.seed;
        end
    end

    adl_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1_valid (s1_valid_reg),
        .s1_item  (s1_item_reg),
        .s1_take  (s1_take),
        .result   (result)
    );

`ifndef SYNTHESIS
    a_empty_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> data_in.ready)
        else $error("lane stage empty but input stalled");
`endif

endmodule
